### design/s2lab_pkg.sv
// Package for the sRGB to CIELAB converter: widths, payload types, fixed-point constants
// and the sRGB linearisation table built at elaboration.
// No dependencies.
package s2lab_pkg;

  // Code and output precision
  localparam int CHANNEL_BITS  = 8;
  localparam int FRACTION_BITS = 8;
  localparam int CODES         = 1 << CHANNEL_BITS;
  localparam longint unsigned CODE_MAX = longint'(CODES - 1);

  // Internal Q.30 fixed point
  localparam int QB      = 30;
  localparam int LIN_W   = QB + 1;          // linear channel, 0 .. 1.0
  localparam int SUM_W   = 44;              // matrix row sum
  localparam int NUM_W   = 51;              // 100 * sum + half divisor
  localparam int RCP_W   = 32;              // reciprocal of the white divisor
  localparam int DIV_W   = 21;              // white divisor
  localparam int TQ_W    = 31;              // white-scaled XYZ and f values
  localparam int SQ_W    = 32;              // square inside the cube root
  localparam int ROOT_BITS = TQ_W;

  // Pipeline depths of the back end
  localparam int CDIV_LAT = 5;
  localparam int CBRT_LAT = 2 * ROOT_BITS;
  localparam int LABF_LAT = CBRT_LAT + 4;
  localparam int BACK_LAT = 1 + CDIV_LAT + LABF_LAT + 2;

  // sRGB to XYZ matrix, ten-thousandths
  localparam int KXR = 4124, KXG = 3576, KXB = 1805;
  localparam int KYR = 2126, KYG = 7152, KYB = 722;
  localparam int KZR = 193,  KZG = 1192, KZB = 9505;

  // White point divisors: X and Z by the D65 white, Y by 10000 written as 100/1e6
  localparam longint unsigned DIV_X = 950489;
  localparam longint unsigned DIV_Y = 1000000;
  localparam longint unsigned DIV_Z = 1088840;
  localparam longint unsigned RCP_X = (64'd1 << NUM_W) / DIV_X;
  localparam longint unsigned RCP_Y = (64'd1 << NUM_W) / DIV_Y;
  localparam longint unsigned RCP_Z = (64'd1 << NUM_W) / DIV_Z;

  // Linear segment of the Lab function: (t*24389 + 432*2^30 + 1566) / 3132
  localparam longint unsigned LF_DEN   = 3132;
  localparam longint unsigned LF_NUM_C = (64'd432 << QB) + 64'd1566;
  localparam longint unsigned LF_CQ    = LF_NUM_C / LF_DEN;
  localparam longint unsigned LF_CR    = LF_NUM_C % LF_DEN;
  localparam longint unsigned LF_RCP   = (64'd1 << 40) / LF_DEN;
  localparam longint unsigned LF_KNEE  = 64'd216 << QB;

  // Output scaling
  localparam int WIDE_W    = 42;
  localparam int OUT_SHIFT = QB - FRACTION_BITS;
  localparam int RND_W     = WIDE_W - OUT_SHIFT + 1;
  localparam int L_MAX     = ((100 << FRACTION_BITS) > 32767) ? 32767 : (100 << FRACTION_BITS);
  localparam int L_W       = 15;
  localparam int AB_W      = 16;

  typedef logic [CHANNEL_BITS-1:0]    code_t;
  typedef logic [LIN_W-1:0]           lin_t;
  typedef logic [TQ_W-1:0]            tq_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;
  typedef logic signed [RND_W-1:0]    rnd_t;
  typedef logic [L_W-1:0]             light_t;
  typedef logic signed [AB_W-1:0]     axis_t;

  typedef struct packed {
    lin_t red;
    lin_t green;
    lin_t blue;
  } lin_rgb_t;

  // Front end to queue
  typedef struct packed {
    logic     push;
    lin_rgb_t data;
  } q_push_t;

  // Queue head to back end
  typedef struct packed {
    logic     valid;
    lin_rgb_t data;
  } q_head_t;

  typedef lin_t lin_tab_t [CODES];

  localparam wide_t L_OFFSET = wide_t'(64'd16 << QB);
  localparam rnd_t  L_MAX_R  = rnd_t'(L_MAX);
  localparam rnd_t  AB_MAX_R = rnd_t'(32767);
  localparam rnd_t  AB_MIN_R = rnd_t'(-32768);

  // ---- Elaboration-time linearisation ----
  function automatic longint unsigned mul_q(longint unsigned a, longint unsigned b);
    return (a * b) >> QB;
  endfunction

  function automatic longint unsigned pow5_q(longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) p = mul_q(p, r);
    return p;
  endfunction

  function automatic longint unsigned root5_q(longint unsigned t);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'd1 << QB;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (pow5_q(mid) <= t) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint unsigned lin_value(longint unsigned c);
    longint unsigned t, t2, r;
    if (c * 100000 <= 4045 * CODE_MAX)
      return (((c * 100) << QB) + (1292 * CODE_MAX) / 2) / (1292 * CODE_MAX);
    t = (((1000 * c + 55 * CODE_MAX) << QB) + (1055 * CODE_MAX) / 2) / (1055 * CODE_MAX);
    if (t > (64'd1 << QB)) t = 64'd1 << QB;
    t2 = (t * t + (64'd1 << (QB - 1))) >> QB;
    r  = root5_q(t2);
    return (t2 * r + (64'd1 << (QB - 1))) >> QB;
  endfunction

  function automatic lin_tab_t build_lin_table();
    lin_tab_t tab;
    for (int i = 0; i < CODES; i++) tab[i] = lin_t'(lin_value(longint'(i)));
    return tab;
  endfunction

  localparam lin_tab_t LIN_TABLE = build_lin_table();

  // Round half away from zero to the output fraction
  function automatic rnd_t round_out(wide_t v);
    logic [WIDE_W-1:0] m;
    logic [WIDE_W-1:0] q;
    m = v[WIDE_W-1] ? (~v + 1'b1) : v;
    q = (m + (WIDE_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    return v[WIDE_W-1] ? -rnd_t'(q) : rnd_t'(q);
  endfunction

  function automatic light_t clamp_light(rnd_t v);
    if (v < 0) return '0;
    if (v > L_MAX_R) return light_t'(L_MAX);
    return v[L_W-1:0];
  endfunction

  function automatic axis_t clamp_axis(rnd_t v);
    if (v < AB_MIN_R) return axis_t'(-32768);
    if (v > AB_MAX_R) return axis_t'(32767);
    return v[AB_W-1:0];
  endfunction

endpackage

### design/s2lab_if.sv
// Handshake channels of the converter: pixel words in, Lab words out.
// Depends on s2lab_pkg.
interface s2lab_pixel_if;
  import s2lab_pkg::*;
  logic  valid;
  logic  ready;
  code_t red_code;
  code_t green_code;
  code_t blue_code;
  modport source (output valid, red_code, green_code, blue_code, input ready);
  modport sink   (input valid, red_code, green_code, blue_code, output ready);
endinterface

interface s2lab_lab_if;
  import s2lab_pkg::*;
  logic   valid;
  logic   ready;
  light_t lightness;
  axis_t  green_red_axis;
  axis_t  blue_yellow_axis;
  modport source (output valid, lightness, green_red_axis, blue_yellow_axis, input ready);
  modport sink   (input valid, lightness, green_red_axis, blue_yellow_axis, output ready);
endinterface

### design/s2lab_front.sv
// Front end: accepts pixel words and linearises each channel through the sRGB table.
// Depends on s2lab_pkg and s2lab_if.
module s2lab_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  s2lab_pixel_if.sink         pixel_i,
  input  logic                full_i,
  output s2lab_pkg::q_push_t  push_o
);
  import s2lab_pkg::*;

  logic     fv_q;
  lin_rgb_t data_q;

  // Holding register moves whenever it is empty or the queue has room
  assign pixel_i.ready = !fv_q || !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (pixel_i.ready) begin
      fv_q <= pixel_i.valid;
    end
  end

  // Table lookups, one per channel
  always_ff @(posedge clk_i) begin
    if (pixel_i.valid && pixel_i.ready) begin
      data_q.red   <= LIN_TABLE[pixel_i.red_code];
      data_q.green <= LIN_TABLE[pixel_i.green_code];
      data_q.blue  <= LIN_TABLE[pixel_i.blue_code];
    end
  end

  assign push_o.push = fv_q && !full_i;
  assign push_o.data = data_q;

endmodule

### design/s2lab_queue.sv
// Two-word queue between front and back end.
// Depends on s2lab_pkg.
module s2lab_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  s2lab_pkg::q_push_t  push_i,
  input  logic                pop_i,
  output logic                full_o,
  output s2lab_pkg::q_head_t  head_o
);
  import s2lab_pkg::*;

  lin_rgb_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o       = (cnt_q == 2'd2);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.data  = mem_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i.push) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i.push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) mem_q[wr_q] <= push_i.data;
  end

endmodule

### design/s2lab_cdiv.sv
// Rounded division of a matrix sum by a white-point divisor, by reciprocal and one
// correction step. Five stages. Depends on s2lab_pkg.
module s2lab_cdiv (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [s2lab_pkg::SUM_W-1:0]  sum_i,
  input  logic [s2lab_pkg::DIV_W-1:0]  divisor_i,
  input  logic [s2lab_pkg::RCP_W-1:0]  recip_i,
  output s2lab_pkg::tq_t               quot_o
);
  import s2lab_pkg::*;

  localparam int LO_W  = 26;
  localparam int HI_W  = NUM_W - LO_W;
  localparam int REM_W = DIV_W + 1;

  logic [NUM_W-1:0]        n0_q, n1_q, n2_q;
  logic [LO_W+RCP_W-1:0]   plo_q;
  logic [HI_W-1:0]         nhi_q;
  logic [RCP_W-1:0]        qe2_q, qe3_q, quot_q;
  logic [REM_W-1:0]        rem_q;
  logic [NUM_W+RCP_W-1:0]  p_full;
  logic [NUM_W+1:0]        r_full;

  // Estimate from split partial products, then remainder
  assign p_full = ((NUM_W+RCP_W)'(nhi_q) * (NUM_W+RCP_W)'(recip_i) << LO_W)
                + (NUM_W+RCP_W)'(plo_q);
  assign r_full = (NUM_W+2)'(n2_q) - (NUM_W+2)'(qe2_q) * (NUM_W+2)'(divisor_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n0_q   <= NUM_W'(sum_i) * NUM_W'(100) + NUM_W'(divisor_i >> 1);
      plo_q  <= (LO_W+RCP_W)'(n0_q[LO_W-1:0]) * (LO_W+RCP_W)'(recip_i);
      nhi_q  <= n0_q[NUM_W-1:LO_W];
      n1_q   <= n0_q;
      qe2_q  <= p_full[NUM_W+RCP_W-1:NUM_W];
      n2_q   <= n1_q;
      rem_q  <= r_full[REM_W-1:0];
      qe3_q  <= qe2_q;
      quot_q <= qe3_q + RCP_W'(rem_q >= REM_W'(divisor_i));
    end
  end

  assign quot_o = quot_q[TQ_W-1:0];

endmodule

### design/s2lab_labf.sv
// Lab transfer function: bit-per-two-stages cube root, then the linear segment below
// the knee and the final choice. Depends on s2lab_pkg.
module s2lab_labf (
  input  logic            clk_i,
  input  logic            en_i,
  input  s2lab_pkg::tq_t  t_i,
  output s2lab_pkg::tq_t  f_o
);
  import s2lab_pkg::*;

  localparam int TL_W = 24;
  localparam int X_W  = 36;
  localparam int QE_W = 25;
  localparam int RM_W = 13;

  tq_t             ra_q [ROOT_BITS];
  tq_t             ca_q [ROOT_BITS];
  tq_t             ta_q [ROOT_BITS];
  logic [SQ_W-1:0] sq_q [ROOT_BITS];
  tq_t             rb_q [ROOT_BITS];
  tq_t             tb_q [ROOT_BITS];

  // Cube root, most significant bit first: square stage then cube-and-compare stage
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_bit
    tq_t                  r_in, t_in, cand;
    logic [2*TQ_W-1:0]    sq_full;
    logic [SQ_W+TQ_W-1:0] cube_full;
    if (k == 0) begin : g_first
      assign r_in = '0;
      assign t_in = t_i;
    end else begin : g_next
      assign r_in = rb_q[k-1];
      assign t_in = tb_q[k-1];
    end
    assign cand      = r_in | (TQ_W'(1) << (ROOT_BITS - 1 - k));
    assign sq_full   = (2*TQ_W)'(cand) * (2*TQ_W)'(cand);
    assign cube_full = (SQ_W+TQ_W)'(sq_q[k]) * (SQ_W+TQ_W)'(ca_q[k]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[k] <= sq_full[QB+SQ_W-1:QB];
        ca_q[k] <= cand;
        ra_q[k] <= r_in;
        ta_q[k] <= t_in;
        rb_q[k] <= (cube_full[SQ_W+TQ_W-1:QB] <= (SQ_W+TQ_W-QB)'(ta_q[k])) ? ca_q[k] : ra_q[k];
        tb_q[k] <= ta_q[k];
      end
    end
  end

  // Tail: knee test, linear segment by reciprocal, select
  tq_t              t_end, r_end;
  logic             big1_q, big2_q, big3_q;
  logic [X_W-1:0]   x1_q, x2_q;
  logic [TL_W-1:0]  tl1_q, tl2_q, tl3_q;
  tq_t              r1_q, r2_q, r3_q, f_q;
  logic [QE_W-1:0]  qe2_q, qe3_q;
  logic [RM_W-1:0]  rem_q;
  logic [X_W+29-1:0] p2;
  logic [X_W-1:0]   r3_full;

  assign t_end   = tb_q[ROOT_BITS-1];
  assign r_end   = rb_q[ROOT_BITS-1];
  assign p2      = (X_W+29)'(x1_q) * (X_W+29)'(LF_RCP);
  assign r3_full = x2_q - X_W'(qe2_q) * X_W'(LF_DEN);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      big1_q <= (48'(t_end) * 48'd24389) > 48'(LF_KNEE);
      x1_q   <= X_W'(t_end[TL_W-1:0]) * X_W'(2465) + X_W'(LF_CR);
      tl1_q  <= t_end[TL_W-1:0];
      r1_q   <= r_end;
      big2_q <= big1_q;
      x2_q   <= x1_q;
      tl2_q  <= tl1_q;
      r2_q   <= r1_q;
      qe2_q  <= p2[40+QE_W-1:40];
      big3_q <= big2_q;
      tl3_q  <= tl2_q;
      r3_q   <= r2_q;
      qe3_q  <= qe2_q;
      rem_q  <= r3_full[RM_W-1:0];
      f_q    <= big3_q ? r3_q
              : TQ_W'(TQ_W'(tl3_q) * TQ_W'(7) + TQ_W'(LF_CQ) + TQ_W'(qe3_q)
                      + TQ_W'(rem_q >= RM_W'(LF_DEN)));
    end
  end

  assign f_o = f_q;

endmodule

### design/s2lab_back.sv
// Back end: matrix, white scaling, Lab function and output scaling, as one stall-together
// pipeline ending in the output register. Depends on s2lab_pkg, s2lab_if, s2lab_cdiv, s2lab_labf.
module s2lab_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  s2lab_pkg::q_head_t  head_i,
  output logic                pop_o,
  s2lab_lab_if.source         lab_o
);
  import s2lab_pkg::*;

  logic [BACK_LAT-1:0] vld_q;
  logic                en;
  logic [SUM_W-1:0]    sx_q, sy_q, sz_q;
  tq_t                 xn, yn, zn, fx, fy, fz;
  wide_t               lq_q, aq_q, bq_q;
  wide_t               fxs, fys, fzs;
  light_t              l_q;
  axis_t               a_q, b_q;

  // Whole pipeline advances unless the output word is held
  assign en    = !vld_q[BACK_LAT-1] || lab_o.ready;
  assign pop_o = en && head_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[BACK_LAT-2:0], pop_o};
    end
  end

  // Matrix rows
  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= SUM_W'(head_i.data.red) * SUM_W'(KXR) + SUM_W'(head_i.data.green) * SUM_W'(KXG)
            + SUM_W'(head_i.data.blue) * SUM_W'(KXB);
      sy_q <= SUM_W'(head_i.data.red) * SUM_W'(KYR) + SUM_W'(head_i.data.green) * SUM_W'(KYG)
            + SUM_W'(head_i.data.blue) * SUM_W'(KYB);
      sz_q <= SUM_W'(head_i.data.red) * SUM_W'(KZR) + SUM_W'(head_i.data.green) * SUM_W'(KZG)
            + SUM_W'(head_i.data.blue) * SUM_W'(KZB);
    end
  end

  // White scaling
  s2lab_cdiv u_div_x (.clk_i, .en_i(en), .sum_i(sx_q), .divisor_i(DIV_W'(DIV_X)),
                      .recip_i(RCP_W'(RCP_X)), .quot_o(xn));
  s2lab_cdiv u_div_y (.clk_i, .en_i(en), .sum_i(sy_q), .divisor_i(DIV_W'(DIV_Y)),
                      .recip_i(RCP_W'(RCP_Y)), .quot_o(yn));
  s2lab_cdiv u_div_z (.clk_i, .en_i(en), .sum_i(sz_q), .divisor_i(DIV_W'(DIV_Z)),
                      .recip_i(RCP_W'(RCP_Z)), .quot_o(zn));

  // Lab function per axis
  s2lab_labf u_f_x (.clk_i, .en_i(en), .t_i(xn), .f_o(fx));
  s2lab_labf u_f_y (.clk_i, .en_i(en), .t_i(yn), .f_o(fy));
  s2lab_labf u_f_z (.clk_i, .en_i(en), .t_i(zn), .f_o(fz));

  assign fxs = wide_t'({{(WIDE_W-TQ_W){1'b0}}, fx});
  assign fys = wide_t'({{(WIDE_W-TQ_W){1'b0}}, fy});
  assign fzs = wide_t'({{(WIDE_W-TQ_W){1'b0}}, fz});

  // L, a, b in Q.30, then round and saturate into the output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      lq_q <= fys * wide_t'(116) - L_OFFSET;
      aq_q <= (fxs - fys) * wide_t'(500);
      bq_q <= (fys - fzs) * wide_t'(200);
      l_q  <= clamp_light(round_out(lq_q));
      a_q  <= clamp_axis(round_out(aq_q));
      b_q  <= clamp_axis(round_out(bq_q));
    end
  end

  assign lab_o.valid            = vld_q[BACK_LAT-1];
  assign lab_o.lightness        = l_q;
  assign lab_o.green_red_axis   = a_q;
  assign lab_o.blue_yellow_axis = b_q;

endmodule

### design/srgb_to_cielab_unit.sv
// Top level of the sRGB (D65) to CIELAB converter.
// Depends on s2lab_pkg, s2lab_if, s2lab_front, s2lab_queue, s2lab_back.
//
//   channel   dir  handshake     word
//   pixel_i   in   valid/ready   red_code, green_code, blue_code (8 b each)
//   lab_o     out  valid/ready   lightness (15 b), green_red_axis, blue_yellow_axis (16 b s)
//
// One word per clock sustained while lab_o is ready. From acceptance to output valid, the
// table lookup registers at the accepting edge, then the word passes the two-word queue and
// the back-end pipeline, most of it the 62-stage cube root (two stages per result bit).
// Reset clears only the valid bits and the queue pointers and count; no clearing pass.
// A held output word freezes the back end; the queue and front register keep taking
// up to three more words before pixel_i.ready drops.
module srgb_to_cielab_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  s2lab_pixel_if.sink  pixel_i,
  s2lab_lab_if.source  lab_o
);
  import s2lab_pkg::*;

  q_push_t push;
  q_head_t head;
  logic    full;
  logic    pop;

  s2lab_front u_front (
    .clk_i, .rst_ni, .pixel_i, .full_i(full), .push_o(push)
  );

  s2lab_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .pop_i(pop), .full_o(full), .head_o(head)
  );

  s2lab_back u_back (
    .clk_i, .rst_ni, .head_i(head), .pop_o(pop), .lab_o
  );

endmodule

### verif/s2lab_checker.sv
// Scoreboard for the sRGB to CIELAB converter: watches the pixel and Lab channels,
// predicts each Lab word from the accepted pixel and compares field by field.
// Depends on s2lab_pkg and s2lab_if.
module s2lab_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  s2lab_pixel_if        pixel_mon,
  s2lab_lab_if          lab_mon,
  output int            fail_count_o,
  output int            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import s2lab_pkg::*;

  localparam int                QF   = 30;
  localparam longint unsigned   UNIT = 64'd1 << QF;
  localparam longint unsigned   CMAX = (64'd1 << CHANNEL_BITS) - 1;

  typedef struct packed {
    light_t lightness;
    axis_t  green_red;
    axis_t  blue_yellow;
  } lab_word_t;

  lab_word_t       lab_expected[$];
  longint unsigned gamma_lut[CODES];
  int              mismatches;

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b) >> QF;
  endfunction

  // Largest Q.30 r with r^n <= t, products truncated at every step
  function automatic longint unsigned root_search(longint unsigned t, longint unsigned top,
                                                  int n);
    longint unsigned lo, hi, mid, p;
    lo = 0;
    hi = top;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      p = mid;
      for (int i = 1; i < n; i++) p = qmul(p, mid);
      if (p <= t) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // sRGB transfer curve: linear below the knee, t^2.4 as t^2 * t^(2/5) above
  function automatic longint unsigned decode_gamma(longint unsigned c);
    longint unsigned t, t2, r, den;
    if (c * 100000 <= 4045 * CMAX) begin
      den = 1292 * CMAX;
      return (((c * 100) << QF) + den / 2) / den;
    end
    den = 1055 * CMAX;
    t = (((1000 * c + 55 * CMAX) << QF) + den / 2) / den;
    if (t > UNIT) t = UNIT;
    t2 = (t * t + (UNIT >> 1)) >> QF;
    r  = root_search(t2, UNIT, 5);
    return (t2 * r + (UNIT >> 1)) >> QF;
  endfunction

  // Lab companding: cube root above (6/29)^3, straight line below
  function automatic longint unsigned lab_curve(longint unsigned t);
    if (t * 24389 > 216 * UNIT) return root_search(t, 2 * UNIT - 1, 3);
    return (t * 841 * 29 + 432 * UNIT + 1566) / 3132;
  endfunction

  // Q.30 to output fraction, half away from zero
  function automatic longint scale_out(longint v);
    longint unsigned m, q;
    m = (v < 0) ? -v : v;
    q = (m + (64'd1 << (QF - FRACTION_BITS - 1))) >> (QF - FRACTION_BITS);
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint saturate(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic lab_word_t convert_pixel(code_t r, code_t g, code_t b);
    longint unsigned lr, lg, lb, sx, sy, sz, fx, fy, fz;
    longint          lq, aq, bq, lmax;
    lab_word_t       w;
    lr = gamma_lut[r];
    lg = gamma_lut[g];
    lb = gamma_lut[b];
    sx = lr * 4124 + lg * 3576 + lb * 1805;
    sy = lr * 2126 + lg * 7152 + lb * 722;
    sz = lr * 193 + lg * 1192 + lb * 9505;
    fx = lab_curve((sx * 100 + 950489 / 2) / 950489);
    fy = lab_curve((sy + 5000) / 10000);
    fz = lab_curve((sz * 100 + 1088840 / 2) / 1088840);
    lq = 116 * longint'(fy) - 16 * longint'(UNIT);
    aq = 500 * (longint'(fx) - longint'(fy));
    bq = 200 * (longint'(fy) - longint'(fz));
    lmax = 100 << FRACTION_BITS;
    if (lmax > 32767) lmax = 32767;
    w.lightness   = light_t'(saturate(scale_out(lq), 0, lmax));
    w.green_red   = axis_t'(saturate(scale_out(aq), -32768, 32767));
    w.blue_yellow = axis_t'(saturate(scale_out(bq), -32768, 32767));
    return w;
  endfunction

  initial begin
    for (int i = 0; i < CODES; i++) gamma_lut[i] = decode_gamma(longint'(i));
  end

  // Predict on every accepted pixel, compare on every accepted Lab word
  always @(posedge clk_i or negedge rst_ni) begin
    lab_word_t got, want;
    if (!rst_ni) begin
      mismatches <= 0;
      lab_expected.delete();
    end else begin
      if (pixel_mon.valid && pixel_mon.ready)
        lab_expected.push_back(convert_pixel(pixel_mon.red_code, pixel_mon.green_code,
                                             pixel_mon.blue_code));
      if (lab_mon.valid && lab_mon.ready) begin
        got.lightness   = lab_mon.lightness;
        got.green_red   = lab_mon.green_red_axis;
        got.blue_yellow = lab_mon.blue_yellow_axis;
        if (lab_expected.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: Lab word with none expected: L=%0d a=%0d b=%0d", $realtime,
                     got.lightness, got.green_red, got.blue_yellow);
          mismatches <= mismatches + 1;
        end else begin
          want = lab_expected.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("%0t: Lab mismatch: expected L=%0d a=%0d b=%0d, got L=%0d a=%0d b=%0d",
                       $realtime, want.lightness, want.green_red, want.blue_yellow,
                       got.lightness, got.green_red, got.blue_yellow);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

  assign fail_count_o = mismatches;
  assign pending_o    = lab_expected.size();

endmodule

### verif/tb_top.sv
// Testbench top for srgb_to_cielab_unit: clock, reset, pixel stimulus and Lab back-pressure.
// Depends on s2lab_pkg, s2lab_if, the converter RTL and s2lab_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import s2lab_pkg::*;

  localparam int RANDOM_WORDS = 650;
  localparam int QUIET_FROM   = 560;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  int   cycles = 0;
  int   words_sent = 0;
  bit   quiet = 1'b0;
  bit   hold_done = 1'b0;

  s2lab_pixel_if pixel_ch();
  s2lab_lab_if   lab_ch();

  srgb_to_cielab_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pixel_i (pixel_ch.sink),
    .lab_o   (lab_ch.source)
  );

  s2lab_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pixel_mon    (pixel_ch),
    .lab_mon      (lab_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one pixel word and wait for it to be taken; optional idle gap after
  task automatic send_pixel(code_t r, code_t g, code_t b);
    pixel_ch.valid      <= 1'b1;
    pixel_ch.red_code   <= r;
    pixel_ch.green_code <= g;
    pixel_ch.blue_code  <= b;
    @(posedge clk_i);
    while (!pixel_ch.ready) @(posedge clk_i);
    words_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      pixel_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Lab sink: random stall bursts, one long hold-off once the stream is going
  initial begin
    lab_ch.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      if (!hold_done && words_sent >= 100) begin
        hold_done = 1'b1;
        lab_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        lab_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        lab_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  initial begin
    code_t corners[$];
    pixel_ch.valid      <= 1'b0;
    pixel_ch.red_code   <= '0;
    pixel_ch.green_code <= '0;
    pixel_ch.blue_code  <= '0;
    corners = '{8'd0, 8'd255, 8'd10, 8'd11, 8'd1, 8'd128, 8'hAA, 8'h55};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: black, white, primaries, secondaries, either side of the gamma knee
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd10,  8'd10,  8'd10);
    send_pixel(8'd11,  8'd11,  8'd11);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd0,   8'd1);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'hAA,  8'h55,  8'hAA);
    send_pixel(8'h55,  8'hAA,  8'h55);
    send_pixel(8'd10,  8'd11,  8'd255);

    // Random: mostly full range, some near the corners and the knee
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i >= QUIET_FROM) quiet = 1'b1;
      if ($urandom_range(0, 4) == 0)
        send_pixel(corners[$urandom_range(0, 7)], corners[$urandom_range(0, 7)],
                   corners[$urandom_range(0, 7)]);
      else
        send_pixel(code_t'($urandom), code_t'($urandom), code_t'($urandom));
    end
    pixel_ch.valid <= 1'b0;
    quiet = 1'b1;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
